// ===== design/bridge_window_mapper_macros.svh =====
// Assertion helpers shared by the window mapper sources.
`ifndef BRIDGE_WINDOW_MAPPER_MACROS_SVH
`define BRIDGE_WINDOW_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BWM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bwm_pkg.sv =====
package bwm_pkg;

  localparam int unsigned NUM_AREAS = 4;
  localparam int unsigned IDX_W = $clog2(NUM_AREAS);
  localparam int unsigned TAG_W = 6;
  localparam int unsigned SZ_W = 14;

  localparam logic [TAG_W-1:0] TAG_RSV = 6'h01;
  localparam logic [TAG_W-1:0] TAG_FREE = 6'h00;

  localparam logic [31:0] MASK_MEM = 32'h0fff_fff0;
  localparam logic [31:0] MASK_IO = 32'h0fff_fffc;
  localparam logic [31:0] CARD_BASE = 32'h0300_0000;
  localparam logic [31:0] MEM_LOW = 32'h0010_0000;
  localparam logic [31:0] IO_MAX = 32'h0000_1000;
  localparam logic [31:0] MEM_MAX = 32'h0008_0000;
  localparam logic [SZ_W-1:0] IO_MIN = 14'h0004;
  localparam logic [SZ_W-1:0] IO_MAX_SZ = 14'h1000;

  localparam logic [1:0] KIND_DIS = 2'd0;
  localparam logic [1:0] KIND_PROG = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOAREA = 3'd1;
  localparam logic [2:0] ST_LONG = 3'd2;
  localparam logic [2:0] ST_ALIGN = 3'd3;
  localparam logic [2:0] ST_LOW = 3'd4;

  typedef struct packed {
    logic match;
    logic free;
  } tbl_stat_t;

endpackage

// ===== design/bwm_area_tbl.sv =====
`include "bridge_window_mapper_macros.svh"

module bwm_area_tbl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bwm_pkg::IDX_W-1:0]      idx_i,
  input  logic [bwm_pkg::TAG_W-1:0]      tag_i,
  input  logic                           wr_en_i,
  input  logic [bwm_pkg::TAG_W-1:0]      wr_tag_i,
  output bwm_pkg::tbl_stat_t             stat_o
);

  logic [bwm_pkg::TAG_W-1:0] tbl_q [bwm_pkg::NUM_AREAS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(bwm_pkg::NUM_AREAS); i++) begin
        tbl_q[i] <= (i == 0) ? bwm_pkg::TAG_RSV : bwm_pkg::TAG_FREE;
      end
    end else if (wr_en_i && (idx_i != '0)) begin
      tbl_q[idx_i] <= wr_tag_i;
    end
  end

  assign stat_o.match = (tbl_q[idx_i] == tag_i);
  assign stat_o.free = (tbl_q[idx_i] == bwm_pkg::TAG_FREE);

  `BWM_ASSERT_IMP(a_rsv_kept, clk_i, rst_ni, 1'b1, tbl_q[0] == bwm_pkg::TAG_RSV,
                  "reserved area entry changed")
  `BWM_ASSERT_IMP(a_alloc_free, clk_i, rst_ni, wr_en_i && (wr_tag_i != bwm_pkg::TAG_FREE),
                  stat_o.free, "area allocated over a used entry")
  `BWM_ASSERT_IMP(a_clear_match, clk_i, rst_ni, wr_en_i && (wr_tag_i == bwm_pkg::TAG_FREE),
                  stat_o.match, "area freed without a tag match")

endmodule

// ===== design/bridge_window_mapper.sv =====
// Window request mapper.
// Input channel: one beat per request (is_io_i, map_number_i, active_i, win_start_i,
// win_end_i, card_offset_i, width_16_i, zero_wait_i) under in_valid_i / in_stall_o.
// Output channel: result beats under out_valid_o / out_stall_i. A request first yields
// one disable beat for each area carrying its tag, then up to two programmed beats, and
// always ends with a status beat that has last_o set.
// How long a request keeps in_stall_o high depends on its path: unmapping only or a refusal
// at the first checks, programming one window, or a split I/O window. The area scans (one
// entry per cycle, waiting while a beat cannot yet be loaded into the output register), the
// window size search (one shift per cycle, up to 11 shifts and a final compare) and the
// single shared 32-bit adder set that time.
// in_stall_o is high from acceptance until the status beat is loaded into the output
// register; the next request can be taken while that beat still waits.
// When out_stall_i is high the output register holds its beat and the sequencer waits
// before producing the next one.
// Reset clears the area table to its initial contents (area 0 reserved, others free),
// empties the output register and returns the sequencer to idle.
`include "bridge_window_mapper_macros.svh"

module bridge_window_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        is_io_i,
  input  logic [3:0]  map_number_i,
  input  logic        active_i,
  input  logic [31:0] win_start_i,
  input  logic [31:0] win_end_i,
  input  logic [23:0] card_offset_i,
  input  logic        width_16_i,
  input  logic        zero_wait_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  area_o,
  output logic [31:0] pci_base_o,
  output logic [31:0] range_mask_o,
  output logic [31:0] local_base_o,
  output logic        bus_width16_o,
  output logic        wait_states_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FREE = 4'd1;
  localparam logic [3:0] S_LEN0 = 4'd2;
  localparam logic [3:0] S_LEN1 = 4'd3;
  localparam logic [3:0] S_DEC = 4'd4;
  localparam logic [3:0] S_SIZE = 4'd5;
  localparam logic [3:0] S_SPLIT = 4'd6;
  localparam logic [3:0] S_H1A = 4'd7;
  localparam logic [3:0] S_H1B = 4'd8;
  localparam logic [3:0] S_H2A = 4'd9;
  localparam logic [3:0] S_H2B = 4'd10;
  localparam logic [3:0] S_HCHK = 4'd11;
  localparam logic [3:0] S_PROG = 4'd12;
  localparam logic [3:0] S_STAT = 4'd13;

  localparam logic [bwm_pkg::IDX_W-1:0] IDX_FIRST = bwm_pkg::IDX_W'(1);
  localparam logic [bwm_pkg::IDX_W-1:0] IDX_LAST = bwm_pkg::IDX_W'(bwm_pkg::NUM_AREAS - 1);

  logic [3:0] state_q, state_d;
  logic [bwm_pkg::IDX_W-1:0] idx_q, idx_d;
  logic io_q, io_d, act_q, act_d, w16_q, w16_d, zw_q, zw_d;
  logic [3:0] map_q, map_d;
  logic [31:0] start_q, start_d, end_q, end_d;
  logic [23:0] coff_q, coff_d;
  logic [31:0] m1a_q, m1a_d, lena_q, lena_d, m1b_q, m1b_d, lenb_q, lenb_d;
  logic [31:0] split_q, split_d;
  logic [bwm_pkg::SZ_W-1:0] sz_q, sz_d, szm1_q, szm1_d;
  logic two_q, two_d, half_q, half_d;
  logic [2:0] st_q, st_d;

  logic out_valid_q, out_valid_d;
  logic [1:0] kind_q, kind_d, area_q, area_d;
  logic [31:0] pci_q, pci_d, mask_q, mask_d, local_q, local_d;
  logic w16o_q, w16o_d, ws_q, ws_d, last_q, last_d;
  logic [2:0] sto_q, sto_d;

  logic [31:0] add_a, add_b, add_sum;
  logic add_c;
  logic out_free;
  logic [bwm_pkg::TAG_W-1:0] tag;
  logic tbl_wr;
  logic [bwm_pkg::TAG_W-1:0] tbl_wr_tag;
  bwm_pkg::tbl_stat_t tbl_stat;
  logic [31:0] diff, prog_base, prog_m1;
  logic align_a, align_b;

  function automatic logic aligned(input logic [31:0] base, input logic [31:0] len,
                                   input logic [31:0] lm1);
    aligned = (len != '0) && ((len & lm1) == '0) && ((base & lm1) == '0);
  endfunction

  assign tag = {1'b1, io_q, map_q};
  assign out_free = !out_valid_q || !out_stall_i;
  assign diff = end_q ^ start_q;
  assign align_a = aligned(start_q, lena_q, m1a_q);
  assign align_b = aligned(split_q, lenb_q, m1b_q);
  assign prog_base = half_q ? split_q : start_q;
  assign prog_m1 = half_q ? m1b_q : m1a_q;

  bwm_area_tbl u_tbl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .idx_i    (idx_q),
    .tag_i    (tag),
    .wr_en_i  (tbl_wr),
    .wr_tag_i (tbl_wr_tag),
    .stat_o   (tbl_stat)
  );

  always_comb begin
    add_a = '0;
    add_b = '0;
    add_c = 1'b0;
    unique case (state_q)
      S_LEN0: begin
        add_a = end_q;
        add_b = ~start_q;
        add_c = 1'b1;
      end
      S_LEN1: begin
        add_a = m1a_q;
        add_c = 1'b1;
      end
      S_SPLIT: begin
        add_a = start_q & ~32'(szm1_q);
        add_b = 32'(sz_q >> 1);
      end
      S_H1A: begin
        add_a = split_q;
        add_b = ~start_q;
      end
      S_H1B: begin
        add_a = m1a_q;
        add_c = 1'b1;
      end
      S_H2A: begin
        add_a = end_q;
        add_b = ~split_q;
        add_c = 1'b1;
      end
      S_H2B: begin
        add_a = m1b_q;
        add_c = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_a + add_b + 32'(add_c);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    io_d = io_q;
    map_d = map_q;
    act_d = act_q;
    start_d = start_q;
    end_d = end_q;
    coff_d = coff_q;
    w16_d = w16_q;
    zw_d = zw_q;
    m1a_d = m1a_q;
    lena_d = lena_q;
    m1b_d = m1b_q;
    lenb_d = lenb_q;
    split_d = split_q;
    sz_d = sz_q;
    szm1_d = szm1_q;
    two_d = two_q;
    half_d = half_q;
    st_d = st_q;
    tbl_wr = 1'b0;
    tbl_wr_tag = bwm_pkg::TAG_FREE;

    out_valid_d = out_valid_q && out_stall_i;
    kind_d = kind_q;
    area_d = area_q;
    pci_d = pci_q;
    mask_d = mask_q;
    local_d = local_q;
    w16o_d = w16o_q;
    ws_d = ws_q;
    sto_d = sto_q;
    last_d = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          io_d = is_io_i;
          map_d = map_number_i;
          act_d = active_i;
          start_d = win_start_i;
          end_d = win_end_i;
          coff_d = card_offset_i;
          w16_d = width_16_i;
          zw_d = zero_wait_i;
          idx_d = IDX_FIRST;
          st_d = bwm_pkg::ST_OK;
          two_d = 1'b0;
          half_d = 1'b0;
          state_d = S_FREE;
        end
      end
      S_FREE: begin
        if (!tbl_stat.match || out_free) begin
          if (tbl_stat.match) begin
            tbl_wr = 1'b1;
            out_valid_d = 1'b1;
            kind_d = bwm_pkg::KIND_DIS;
            area_d = 2'(idx_q);
            pci_d = '0;
            mask_d = '0;
            local_d = '0;
            w16o_d = 1'b0;
            ws_d = 1'b0;
            sto_d = bwm_pkg::ST_OK;
            last_d = 1'b0;
          end
          if (idx_q == IDX_LAST) begin
            state_d = S_LEN0;
          end else begin
            idx_d = idx_q + IDX_FIRST;
          end
        end
      end
      S_LEN0: begin
        m1a_d = add_sum;
        state_d = S_LEN1;
      end
      S_LEN1: begin
        lena_d = add_sum;
        state_d = S_DEC;
      end
      S_DEC: begin
        idx_d = IDX_FIRST;
        sz_d = bwm_pkg::IO_MIN;
        szm1_d = bwm_pkg::IO_MIN - bwm_pkg::SZ_W'(1);
        priority if (!act_q) begin
          state_d = S_STAT;
        end else if (io_q) begin
          priority if (lena_q > bwm_pkg::IO_MAX) begin
            st_d = bwm_pkg::ST_LONG;
            state_d = S_STAT;
          end else if (align_a) begin
            state_d = S_PROG;
          end else begin
            two_d = 1'b1;
            state_d = S_SIZE;
          end
        end else begin
          priority if (start_q < bwm_pkg::MEM_LOW) begin
            st_d = bwm_pkg::ST_LOW;
            state_d = S_STAT;
          end else if (lena_q > bwm_pkg::MEM_MAX) begin
            st_d = bwm_pkg::ST_LONG;
            state_d = S_STAT;
          end else if (!align_a) begin
            st_d = bwm_pkg::ST_ALIGN;
            state_d = S_STAT;
          end else begin
            state_d = S_PROG;
          end
        end
      end
      S_SIZE: begin
        if ((sz_q <= bwm_pkg::IO_MAX_SZ) && (32'(sz_q) <= diff)) begin
          sz_d = {sz_q[bwm_pkg::SZ_W-2:0], 1'b0};
          szm1_d = {szm1_q[bwm_pkg::SZ_W-2:0], 1'b1};
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        split_d = add_sum;
        state_d = S_H1A;
      end
      S_H1A: begin
        m1a_d = add_sum;
        state_d = S_H1B;
      end
      S_H1B: begin
        lena_d = add_sum;
        state_d = S_H2A;
      end
      S_H2A: begin
        m1b_d = add_sum;
        state_d = S_H2B;
      end
      S_H2B: begin
        lenb_d = add_sum;
        state_d = S_HCHK;
      end
      S_HCHK: begin
        if (align_a && align_b) begin
          state_d = S_PROG;
        end else begin
          st_d = bwm_pkg::ST_ALIGN;
          state_d = S_STAT;
        end
      end
      S_PROG: begin
        if (tbl_stat.free) begin
          if (out_free) begin
            tbl_wr = 1'b1;
            tbl_wr_tag = tag;
            out_valid_d = 1'b1;
            kind_d = bwm_pkg::KIND_PROG;
            area_d = 2'(idx_q);
            pci_d = prog_base | {31'b0, io_q};
            mask_d = io_q ? ((~prog_m1 & bwm_pkg::MASK_IO) | 32'h1)
                          : (~prog_m1 & bwm_pkg::MASK_MEM);
            local_d = io_q ? 32'h1 : ({8'h0, coff_q} | bwm_pkg::CARD_BASE | 32'h1);
            w16o_d = w16_q;
            ws_d = !zw_q;
            sto_d = bwm_pkg::ST_OK;
            last_d = 1'b0;
            if (two_q && !half_q) begin
              half_d = 1'b1;
              if (idx_q == IDX_LAST) begin
                st_d = bwm_pkg::ST_NOAREA;
                state_d = S_STAT;
              end else begin
                idx_d = idx_q + IDX_FIRST;
              end
            end else begin
              state_d = S_STAT;
            end
          end
        end else if (idx_q == IDX_LAST) begin
          st_d = bwm_pkg::ST_NOAREA;
          state_d = S_STAT;
        end else begin
          idx_d = idx_q + IDX_FIRST;
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d = bwm_pkg::KIND_STAT;
          area_d = '0;
          pci_d = '0;
          mask_d = '0;
          local_d = '0;
          w16o_d = 1'b0;
          ws_d = 1'b0;
          sto_d = st_q;
          last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    io_q <= io_d;
    map_q <= map_d;
    act_q <= act_d;
    start_q <= start_d;
    end_q <= end_d;
    coff_q <= coff_d;
    w16_q <= w16_d;
    zw_q <= zw_d;
    m1a_q <= m1a_d;
    lena_q <= lena_d;
    m1b_q <= m1b_d;
    lenb_q <= lenb_d;
    split_q <= split_d;
    sz_q <= sz_d;
    szm1_q <= szm1_d;
    two_q <= two_d;
    half_q <= half_d;
    st_q <= st_d;
    kind_q <= kind_d;
    area_q <= area_d;
    pci_q <= pci_d;
    mask_q <= mask_d;
    local_q <= local_d;
    w16o_q <= w16o_d;
    ws_q <= ws_d;
    sto_q <= sto_d;
    last_q <= last_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign area_o = area_q;
  assign pci_base_o = pci_q;
  assign range_mask_o = mask_q;
  assign local_base_o = local_q;
  assign bus_width16_o = w16o_q;
  assign wait_states_o = ws_q;
  assign status_o = sto_q;
  assign last_o = last_q;

  `BWM_ASSERT_NXT(a_accept_frees, clk_i, rst_ni, in_valid_i && !in_stall_o,
                  state_q == S_FREE, "accepted beat did not start the free scan")
  `BWM_ASSERT_NXT(a_status_idle, clk_i, rst_ni, (state_q == S_STAT) && out_free,
                  (state_q == S_IDLE) && out_valid_q && last_q,
                  "status beat not loaded on the way back to idle")
  `BWM_ASSERT_IMP(a_last_kind, clk_i, rst_ni, out_valid_q,
                  last_q == (kind_q == bwm_pkg::KIND_STAT), "last flag disagrees with kind")

endmodule

// ===== test/bwm_window_checker.sv =====
module bwm_window_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        is_io_i,
  input  logic [3:0]  map_number_i,
  input  logic        active_i,
  input  logic [31:0] win_start_i,
  input  logic [31:0] win_end_i,
  input  logic [23:0] card_offset_i,
  input  logic        width_16_i,
  input  logic        zero_wait_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  area_i,
  input  logic [31:0] pci_base_i,
  input  logic [31:0] range_mask_i,
  input  logic [31:0] local_base_i,
  input  logic        bus_width16_i,
  input  logic        wait_states_i,
  input  logic [2:0]  status_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  area;
    logic [31:0] pci_base;
    logic [31:0] range_mask;
    logic [31:0] local_base;
    logic        bus_width16;
    logic        wait_states;
    logic [2:0]  status;
    logic        last;
  } win_beat_t;

  logic [bwm_pkg::TAG_W-1:0] area_tbl [bwm_pkg::NUM_AREAS];
  win_beat_t                 expected_beats[$];

  initial fail_count_o = 0;
  initial outstanding_o = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic logic size_aligned(logic [31:0] base, logic [31:0] len);
    return (len != 32'd0) && ((len & (len - 32'd1)) == 32'd0) &&
           ((base & (len - 32'd1)) == 32'd0);
  endfunction

  // Takes the lowest free area for one window and queues its programmed beat.
  task automatic claim_area(input logic [bwm_pkg::TAG_W-1:0] tag, input logic io,
                            input logic [31:0] base, input logic [31:0] len,
                            input logic [31:0] loc_base, input logic w16,
                            input logic zw, output logic ok);
    win_beat_t   b;
    logic [31:0] mask;
    ok = 1'b0;
    for (int i = 1; i < int'(bwm_pkg::NUM_AREAS); i++) begin
      if (!ok && area_tbl[i] == bwm_pkg::TAG_FREE) begin
        area_tbl[i] = tag;
        mask = ~(len - 32'd1);
        if (io) begin
          mask = (mask & bwm_pkg::MASK_IO) | 32'd1;
        end else begin
          mask = mask & bwm_pkg::MASK_MEM;
        end
        b = '0;
        b.kind = bwm_pkg::KIND_PROG;
        b.area = 2'(i);
        b.pci_base = base | {31'd0, io};
        b.range_mask = mask;
        b.local_base = loc_base | 32'd1;
        b.bus_width16 = w16;
        b.wait_states = !zw;
        b.status = bwm_pkg::ST_OK;
        expected_beats.push_back(b);
        ok = 1'b1;
      end
    end
  endtask

  task automatic predict_request(input logic io, input logic [3:0] map, input logic act,
                                 input logic [31:0] start, input logic [31:0] stop,
                                 input logic [23:0] coff, input logic w16,
                                 input logic zw);
    logic [bwm_pkg::TAG_W-1:0] tag;
    logic [2:0]                st;
    logic [31:0]               len;
    logic [31:0]               diff;
    logic [31:0]               sz;
    logic [31:0]               split;
    logic                      ok;
    win_beat_t                 b;
    tag = {1'b1, io, map};
    st = bwm_pkg::ST_OK;
    for (int i = 1; i < int'(bwm_pkg::NUM_AREAS); i++) begin
      if (area_tbl[i] == tag) begin
        area_tbl[i] = bwm_pkg::TAG_FREE;
        b = '0;
        b.kind = bwm_pkg::KIND_DIS;
        b.area = 2'(i);
        expected_beats.push_back(b);
      end
    end
    if (act) begin
      len = stop + 32'd1 - start;
      if (io) begin
        if (len > bwm_pkg::IO_MAX) begin
          st = bwm_pkg::ST_LONG;
        end else if (size_aligned(start, len)) begin
          claim_area(tag, 1'b1, start, len, 32'd0, w16, zw, ok);
          if (!ok) st = bwm_pkg::ST_NOAREA;
        end else begin
          // An unaligned I/O window is split at the midpoint of the smallest
          // aligned block that holds both ends.
          diff = stop ^ start;
          sz = 32'(bwm_pkg::IO_MIN);
          while (sz <= bwm_pkg::IO_MAX && sz <= diff) sz = sz << 1;
          split = (start & ~(sz - 32'd1)) + (sz >> 1);
          if (!size_aligned(start, split - start) ||
              !size_aligned(split, stop + 32'd1 - split)) begin
            st = bwm_pkg::ST_ALIGN;
          end else begin
            claim_area(tag, 1'b1, start, split - start, 32'd0, w16, zw, ok);
            if (!ok) begin
              st = bwm_pkg::ST_NOAREA;
            end else begin
              claim_area(tag, 1'b1, split, stop + 32'd1 - split, 32'd0, w16, zw, ok);
              if (!ok) st = bwm_pkg::ST_NOAREA;
            end
          end
        end
      end else begin
        if (start < bwm_pkg::MEM_LOW) begin
          st = bwm_pkg::ST_LOW;
        end else if (len > bwm_pkg::MEM_MAX) begin
          st = bwm_pkg::ST_LONG;
        end else if (!size_aligned(start, len)) begin
          st = bwm_pkg::ST_ALIGN;
        end else begin
          claim_area(tag, 1'b0, start, len, {8'd0, coff} | bwm_pkg::CARD_BASE, w16, zw,
                     ok);
          if (!ok) st = bwm_pkg::ST_NOAREA;
        end
      end
    end
    b = '0;
    b.kind = bwm_pkg::KIND_STAT;
    b.status = st;
    b.last = 1'b1;
    expected_beats.push_back(b);
  endtask

  task automatic check_result_beat();
    win_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("unexpected beat, kind", 32'(kind_i), 32'd0);
    end else begin
      want = expected_beats.pop_front();
      if (kind_i !== want.kind) report_mismatch("kind", 32'(kind_i), 32'(want.kind));
      if (area_i !== want.area) report_mismatch("area", 32'(area_i), 32'(want.area));
      if (pci_base_i !== want.pci_base) begin
        report_mismatch("pci_base", pci_base_i, want.pci_base);
      end
      if (range_mask_i !== want.range_mask) begin
        report_mismatch("range_mask", range_mask_i, want.range_mask);
      end
      if (local_base_i !== want.local_base) begin
        report_mismatch("local_base", local_base_i, want.local_base);
      end
      if (bus_width16_i !== want.bus_width16) begin
        report_mismatch("bus_width16", 32'(bus_width16_i), 32'(want.bus_width16));
      end
      if (wait_states_i !== want.wait_states) begin
        report_mismatch("wait_states", 32'(wait_states_i), 32'(want.wait_states));
      end
      if (status_i !== want.status) report_mismatch("status", 32'(status_i), 32'(want.status));
      if (last_i !== want.last) report_mismatch("last", 32'(last_i), 32'(want.last));
    end
  endtask

  // Result beats are checked before the request beat of the same edge is
  // predicted, since a request cannot produce a result in its own cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(bwm_pkg::NUM_AREAS); i++) area_tbl[i] = bwm_pkg::TAG_FREE;
      area_tbl[0] = bwm_pkg::TAG_RSV;
      expected_beats.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result_beat();
      if (in_valid_i && !in_stall_i) begin
        predict_request(is_io_i, map_number_i, active_i, win_start_i, win_end_i,
                        card_offset_i, width_16_i, zero_wait_i);
      end
    end
    outstanding_o = expected_beats.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;

  typedef struct packed {
    logic        is_io;
    logic [3:0]  map_number;
    logic        active;
    logic [31:0] win_start;
    logic [31:0] win_end;
    logic [23:0] card_offset;
    logic        width_16;
    logic        zero_wait;
  } win_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        is_io_i = 1'b0;
  logic [3:0]  map_number_i = '0;
  logic        active_i = 1'b0;
  logic [31:0] win_start_i = '0;
  logic [31:0] win_end_i = '0;
  logic [23:0] card_offset_i = '0;
  logic        width_16_i = 1'b0;
  logic        zero_wait_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [1:0]  area_o;
  logic [31:0] pci_base_o;
  logic [31:0] range_mask_o;
  logic [31:0] local_base_o;
  logic        bus_width16_o;
  logic        wait_states_o;
  logic [2:0]  status_o;
  logic        last_o;

  int fail_count;
  int outstanding;
  int send_idle_pct = 6;
  int recv_idle_pct = 52;

  bridge_window_mapper i_dut (.*);

  bwm_window_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .is_io_i       (is_io_i),
    .map_number_i  (map_number_i),
    .active_i      (active_i),
    .win_start_i   (win_start_i),
    .win_end_i     (win_end_i),
    .card_offset_i (card_offset_i),
    .width_16_i    (width_16_i),
    .zero_wait_i   (zero_wait_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .area_i        (area_o),
    .pci_base_i    (pci_base_o),
    .range_mask_i  (range_mask_o),
    .local_base_i  (local_base_o),
    .bus_width16_i (bus_width16_o),
    .wait_states_i (wait_states_o),
    .status_i      (status_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic win_req_t window_req(logic io, logic [3:0] map, logic act,
                                          logic [31:0] start, logic [31:0] stop,
                                          logic [23:0] coff, logic w16, logic zw);
    win_req_t r;
    r.is_io = io;
    r.map_number = map;
    r.active = act;
    r.win_start = start;
    r.win_end = stop;
    r.card_offset = coff;
    r.width_16 = w16;
    r.zero_wait = zw;
    return r;
  endfunction

  task automatic send_req(input win_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    is_io_i <= r.is_io;
    map_number_i <= r.map_number;
    active_i <= r.active;
    win_start_i <= r.win_start;
    win_end_i <= r.win_end;
    card_offset_i <= r.card_offset;
    width_16_i <= r.width_16;
    zero_wait_i <= r.zero_wait;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly well-formed windows with random content, some near misses and
  // some fully random requests.
  task automatic send_random_req();
    win_req_t    r;
    int unsigned roll;
    int unsigned k;
    int unsigned p;
    int unsigned q;
    logic [31:0] size;
    logic [31:0] split;
    roll = $urandom_range(99);
    r.is_io = 1'($urandom);
    r.map_number = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom);
    r.active = ($urandom_range(99) < 85);
    r.card_offset = 24'($urandom);
    r.width_16 = 1'($urandom);
    r.zero_wait = 1'($urandom);
    if (roll < 80) begin
      if (r.is_io && $urandom_range(1)) begin
        k = $urandom_range(11, 2);
        p = $urandom_range(k, 2);
        q = $urandom_range(k, 2);
        split = ($urandom & ~((32'd2 << k) - 32'd1)) | (32'd1 << k);
        r.win_start = split - (32'd1 << p);
        r.win_end = split + (32'd1 << q) - 32'd1;
      end else begin
        k = r.is_io ? $urandom_range(12, 2) : $urandom_range(19, 4);
        size = 32'd1 << k;
        r.win_start = $urandom & ~(size - 32'd1);
        if (!r.is_io && r.win_start < bwm_pkg::MEM_LOW) begin
          r.win_start = r.win_start | bwm_pkg::MEM_LOW;
        end
        r.win_end = r.win_start + size - 32'd1;
      end
      if (roll >= 70) r.win_end = r.win_end ^ (32'd1 << $urandom_range(4));
    end else begin
      r.win_start = $urandom;
      r.win_end = $urandom_range(1) ? 32'($urandom) : r.win_start + $urandom_range(32'h1fff);
    end
    send_req(r);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_req(window_req(1'b0, 4'd1, 1'b1, 32'h0010_0000, 32'h0010_ffff, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b0, 4'd1, 1'b1, 32'h0010_0000, 32'h0010_ffff, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b1, 4'd2, 1'b1, 32'h0000_0100, 32'h0000_01ff, 24'h0, 1'b1, 1'b0));
    // The second half of this split finds no free area.
    send_req(window_req(1'b1, 4'd3, 1'b1, 32'h0000_03f8, 32'h0000_0407, 24'h0, 1'b0, 1'b1));
    send_req(window_req(1'b0, 4'd4, 1'b1, 32'h0020_0000, 32'h0027_ffff, 24'hff_ffff, 1'b1,
                        1'b1));
    send_req(window_req(1'b1, 4'd2, 1'b0, 32'h0, 32'h0, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b1, 4'd3, 1'b0, 32'h0, 32'h0, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b1, 4'd3, 1'b1, 32'h0000_03f8, 32'h0000_0407, 24'h0, 1'b1, 1'b1));
    send_req(window_req(1'b1, 4'd3, 1'b0, 32'h0, 32'h0, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b0, 4'd4, 1'b1, 32'h0020_0000, 32'h0027_ffff, 24'hff_ffff, 1'b1,
                        1'b1));
    send_req(window_req(1'b0, 4'd5, 1'b1, 32'h000f_ffff, 32'h000f_ffff, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b0, 4'd5, 1'b1, 32'h0020_0000, 32'h0028_0000, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b0, 4'd5, 1'b1, 32'h0030_0010, 32'h0030_002f, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b0, 4'd5, 1'b1, 32'h0040_0000, 32'h003f_ffff, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b0, 4'd5, 1'b1, 32'h0050_0000, 32'h0040_0000, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b1, 4'd6, 1'b1, 32'h0000_0000, 32'h0000_1000, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b1, 4'd6, 1'b1, 32'h0000_03f4, 32'h0000_040b, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b1, 4'd6, 1'b1, 32'h0000_1ffc, 32'h0000_2003, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b1, 4'd15, 1'b1, 32'hffff_fffc, 32'hffff_ffff, 24'h0, 1'b1,
                        1'b0));
    send_req(window_req(1'b0, 4'd15, 1'b1, 32'hfff8_0000, 32'hffff_ffff, 24'h0, 1'b0,
                        1'b1));
    send_req(window_req(1'b1, 4'd0, 1'b1, 32'hffff_fffc, 32'h0000_0003, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b0, 4'd0, 1'b0, 32'h0, 32'h0, 24'h0, 1'b0, 1'b0));
    send_req(window_req(1'b1, 4'd15, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 24'hff_ffff, 1'b1,
                        1'b1));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 6 : 0;
      repeat (79) send_random_req();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
